// File: rtl/sme_pkg.sv
package sme_pkg;

    // Opcodes of the instruction set. Codes 12 to 15 are unused and act as no-ops.
    typedef enum logic [3:0] {
        OP_HALT        = 4'd0,
        OP_LABEL       = 4'd1,
        OP_JUMP        = 4'd2,
        OP_JZ          = 4'd3,
        OP_RET         = 4'd4,
        OP_DUP         = 4'd5,
        OP_SWAP        = 4'd6,
        OP_DROP        = 4'd7,
        OP_PUSH_INT    = 4'd8,
        OP_PUSH_TARGET = 4'd9,
        OP_GE          = 4'd10,
        OP_ADD         = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_UNDER  = 3'd1,
        ERR_OVER   = 3'd2,
        ERR_SELF   = 3'd3,
        ERR_HALTED = 3'd4
    } err_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [63:0] imm_value;
        logic [8:0]         stack_offset;
        logic [15:0]        target;
    } sme_req_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic signed [63:0] top_value;
        logic [8:0]         depth;
        logic               halted;
        logic [2:0]         error;
    } sme_rsp_t;

endpackage

// File: rtl/sme_stack_ram.sv
module sme_stack_ram
    import sme_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one read port; the read data is registered and
    // holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/stack_machine_execute.sv
// Stack-machine instruction executor.
//
// Each request on the s_ channel (s_valid, s_ready, s_req) carries one
// instruction. For every request the block returns exactly one response on
// the m_ channel (m_valid, m_ready, m_rsp) holding the new program counter,
// the top of stack, the depth, the halted flag and an error code.
//
// An instruction is accepted in the idle state, where the accepting edge
// issues the one stack memory read the instruction needs. The execute state
// then executes it, writes the memory and loads the response register. Swap
// writes two stack entries through the single write port, the second one in
// a separate swap state. New requests are accepted only in the idle state.
//
// The response register lets the next request be accepted while a response
// still waits. If the receiver stalls, the following instruction waits in its
// execute cycle until the response register is free, so no response is lost.
//
// Reset clears the program counter, the depth and the halted flag. The stack
// memory is not cleared; only entries below the depth are ever used.
module stack_machine_execute
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int PC_WIDTH    = 16,
    parameter int WORD_WIDTH  = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sme_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output sme_rsp_t m_rsp
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    // Width for depth and offset arithmetic with room for a borrow.
    localparam int CW = ((DW > 9) ? DW : 9) + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWAP2 = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    sme_req_t              req_reg, req_next;
    sme_rsp_t              rsp_reg, rsp_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PC_WIDTH-1:0]   pc_reg, pc_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic                  halt_reg, halt_next;
    logic [WORD_WIDTH-1:0] tos_reg, tos_next;

    // Stack memory port signals.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    // Execute-cycle results, before they are committed.
    err_t                  exec_err;
    logic [PC_WIDTH-1:0]   exec_pc;
    logic [DW-1:0]         exec_depth;
    logic                  exec_halt;
    logic [WORD_WIDTH-1:0] exec_tos;
    logic                  exec_we;
    logic [AW-1:0]         exec_waddr;
    logic [WORD_WIDTH-1:0] exec_wdata;
    logic                  exec_swap;
    logic                  exec_commit;
    logic                  out_free;

    logic [CW-1:0]         n_c;
    logic [CW-1:0]         off_c;
    logic [CW-1:0]         in_off_c;
    logic [CW-1:0]         rd_addr_c;
    logic [PC_WIDTH-1:0]   pc_inc;
    logic [WORD_WIDTH-1:0] word_sum;
    logic                  word_ge;

    sme_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_rsp    = rsp_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The read is issued on the accepting edge. Dup, swap and drop read the
    // entry at the offset below the top; every other op reads the entry just
    // below the top, which becomes the new top after a pop or is the first
    // operand of add and ge. Writes happen only outside the idle state, so a
    // read never meets a write to the same entry in the same cycle.
    assign n_c      = CW'(depth_reg);
    assign in_off_c = CW'(s_req.stack_offset);

    always_comb begin
        if (s_req.op inside {OP_DUP, OP_SWAP, OP_DROP}) begin
            rd_addr_c = n_c - CW'(1) - in_off_c;
        end else begin
            rd_addr_c = n_c - CW'(2);
        end
    end

    assign mem_re    = s_valid && s_ready;
    assign mem_raddr = rd_addr_c[AW-1:0];

    // Execute stage. The read data is the entry chosen at accept time and the
    // top of stack is held in tos_reg, which is valid whenever depth is not
    // zero. A faulting instruction changes nothing.
    assign off_c    = CW'(req_reg.stack_offset);
    assign pc_inc   = pc_reg + PC_WIDTH'(1);
    assign word_sum = mem_rdata + tos_reg;
    assign word_ge  = ($signed(mem_rdata) >= $signed(tos_reg));

    always_comb begin
        exec_err   = ERR_OK;
        exec_pc    = pc_reg;
        exec_depth = depth_reg;
        exec_halt  = halt_reg;
        exec_tos   = tos_reg;
        exec_we    = 1'b0;
        exec_waddr = n_c[AW-1:0];
        exec_wdata = mem_rdata;
        exec_swap  = 1'b0;
        if (halt_reg) begin
            exec_err = ERR_HALTED;
        end else begin
            case (req_reg.op)
                OP_HALT: begin
                    exec_halt = 1'b1;
                end
                OP_JUMP: begin
                    exec_pc = PC_WIDTH'(req_reg.target);
                end
                OP_JZ, OP_RET: begin
                    if (n_c < CW'(1)) begin
                        exec_err = ERR_UNDER;
                    end else begin
                        exec_depth = DW'(n_c - CW'(1));
                        exec_tos   = mem_rdata;
                        if (req_reg.op == OP_RET) begin
                            exec_pc = PC_WIDTH'(tos_reg);
                        end else if (tos_reg == '0) begin
                            exec_pc = PC_WIDTH'(req_reg.target);
                        end else begin
                            exec_pc = pc_inc;
                        end
                    end
                end
                OP_DUP: begin
                    if (off_c + CW'(1) > n_c) begin
                        exec_err = ERR_UNDER;
                    end else if (n_c >= CW'(STACK_DEPTH)) begin
                        exec_err = ERR_OVER;
                    end else begin
                        exec_we    = 1'b1;
                        exec_tos   = mem_rdata;
                        exec_depth = DW'(n_c + CW'(1));
                        exec_pc    = pc_inc;
                    end
                end
                OP_SWAP: begin
                    if (off_c + CW'(1) > n_c) begin
                        exec_err = ERR_UNDER;
                    end else if (off_c == '0) begin
                        exec_err = ERR_SELF;
                    end else begin
                        // The old top goes down now; the read word is written
                        // to the top entry in the following cycle.
                        exec_we    = 1'b1;
                        exec_swap  = 1'b1;
                        exec_waddr = AW'(n_c - CW'(1) - off_c);
                        exec_wdata = tos_reg;
                        exec_tos   = mem_rdata;
                        exec_pc    = pc_inc;
                    end
                end
                OP_DROP: begin
                    if (off_c > n_c) begin
                        exec_err = ERR_UNDER;
                    end else begin
                        exec_depth = DW'(n_c - off_c);
                        exec_tos   = mem_rdata;
                        exec_pc    = pc_inc;
                    end
                end
                OP_PUSH_INT, OP_PUSH_TARGET: begin
                    if (n_c >= CW'(STACK_DEPTH)) begin
                        exec_err = ERR_OVER;
                    end else begin
                        exec_we    = 1'b1;
                        exec_wdata = (req_reg.op == OP_PUSH_INT)
                                   ? WORD_WIDTH'(req_reg.imm_value)
                                   : WORD_WIDTH'(req_reg.target);
                        exec_tos   = exec_wdata;
                        exec_depth = DW'(n_c + CW'(1));
                        exec_pc    = pc_inc;
                    end
                end
                OP_GE, OP_ADD: begin
                    if (n_c < CW'(2)) begin
                        exec_err = ERR_UNDER;
                    end else begin
                        exec_we    = 1'b1;
                        exec_waddr = AW'(n_c - CW'(2));
                        exec_wdata = (req_reg.op == OP_ADD)
                                   ? word_sum
                                   : WORD_WIDTH'(word_ge);
                        exec_tos   = exec_wdata;
                        exec_depth = DW'(n_c - CW'(1));
                        exec_pc    = pc_inc;
                    end
                end
                default: begin
                    // Label and the unused codes only advance the pc.
                    exec_pc = pc_inc;
                end
            endcase
        end
    end

    assign exec_commit = (state_reg == ST_EXEC) && out_free;

    // Memory write: the execute write, or the second half of a swap, which
    // puts the word read at accept time (still held) on the top entry.
    always_comb begin
        if (state_reg == ST_SWAP2) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(n_c - CW'(1));
            mem_wdata = mem_rdata;
        end else begin
            mem_we    = exec_commit && exec_we;
            mem_waddr = exec_waddr;
            mem_wdata = exec_wdata;
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg;
        pc_next      = pc_reg;
        depth_next   = depth_reg;
        halt_next    = halt_reg;
        tos_next     = tos_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    pc_next            = exec_pc;
                    depth_next         = exec_depth;
                    halt_next          = exec_halt;
                    tos_next           = exec_tos;
                    rsp_next.next_pc   = 16'(exec_pc);
                    rsp_next.top_value = (exec_depth != '0)
                                       ? 64'($signed(exec_tos)) : '0;
                    rsp_next.depth     = 9'(exec_depth);
                    rsp_next.halted    = exec_halt;
                    rsp_next.error     = exec_err;
                    m_valid_next       = 1'b1;
                    state_next         = exec_swap ? ST_SWAP2 : ST_IDLE;
                end
            end
            ST_SWAP2: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pc_reg      <= '0;
            depth_reg   <= '0;
            halt_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pc_reg      <= pc_next;
            depth_reg   <= depth_next;
            halt_reg    <= halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        tos_reg <= tos_next;
    end

    // The depth never passes the stack size.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // Once halted, the block stays halted until reset.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halted flag cleared without reset");

    // No memory write while a read may be issued, so no forwarding is needed.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("stack write during accept cycle");

    // A faulting instruction leaves pc and depth unchanged.
    a_fault_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_commit && exec_err != ERR_OK) |=> ($stable(depth_reg) && $stable(pc_reg)))
        else $error("faulting instruction changed state");

    // An already-halted response always reports the halted flag.
    a_halted_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.error == ERR_HALTED) |-> m_rsp.halted)
        else $error("halted error without halted flag");

endmodule

// File: bench/stack_machine_execute_tb.sv
module stack_machine_execute_tb;
    import sme_pkg::*;

    // Depth of the stack in the block as built here.
    localparam int STACK_WORDS = 256;

    // Codes 12 to 15 have no name in the package. The block treats them as a
    // plain step of the program counter.
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    // Words that sit at the edges of the signed range, and the all-ones word.
    localparam logic [63:0] WORD_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WORD_ONES = 64'hffff_ffff_ffff_ffff;

    // Clock, reset and the two channels. Every input has a known value
    // from time zero.
    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sme_req_t s_req   = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sme_rsp_t m_rsp;

    stack_machine_execute uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the machine. It is advanced once per accepted request,
    // in the order the block accepts them, so its state always matches what
    // the block should hold after the last accepted instruction.
    logic [63:0] stack_words [0:STACK_WORDS-1];
    logic [8:0]  stack_count = '0;
    logic [15:0] cur_pc      = '0;
    logic        is_halted   = 1'b0;

    // Responses that the block still owes, oldest first.
    sme_rsp_t pending_results [$];

    // Bookkeeping for the summary and the verdict.
    int fail_count   = 0;
    int instr_count  = 0;
    int result_count = 0;
    int deepest      = 0;
    int fault_hits [0:4] = '{default: 0};

    // When set, the request side sends back to back with no gaps.
    bit sender_eager = 1'b0;

    // Executes one instruction on the shadow machine and returns the response
    // that the block has to give for it. A faulting instruction leaves the
    // state alone and the response simply reports the state as it was.
    function automatic sme_rsp_t execute_instr(input sme_req_t req);
        sme_rsp_t    rsp;
        err_t        err;
        logic [15:0] pc_inc;
        logic [63:0] lower;
        logic [63:0] upper;
        int          n;
        int          off;
        n      = int'(stack_count);
        off    = int'(req.stack_offset);
        pc_inc = cur_pc + 16'd1;
        err    = ERR_OK;
        if (is_halted) begin
            err = ERR_HALTED;
        end else begin
            case (req.op)
                OP_HALT: begin
                    // The pc stays on the halt instruction.
                    is_halted = 1'b1;
                end
                OP_JUMP: begin
                    cur_pc = req.target;
                end
                OP_JZ: begin
                    if (n < 1) begin
                        err = ERR_UNDER;
                    end else begin
                        // The whole word is tested, not just its low bits.
                        cur_pc      = (stack_words[n-1] == '0) ? req.target : pc_inc;
                        stack_count = 9'(n - 1);
                    end
                end
                OP_RET: begin
                    if (n < 1) begin
                        err = ERR_UNDER;
                    end else begin
                        cur_pc      = stack_words[n-1][15:0];
                        stack_count = 9'(n - 1);
                    end
                end
                OP_DUP: begin
                    if (off + 1 > n) begin
                        err = ERR_UNDER;
                    end else if (n >= STACK_WORDS) begin
                        err = ERR_OVER;
                    end else begin
                        stack_words[n] = stack_words[n-1-off];
                        stack_count    = 9'(n + 1);
                        cur_pc         = pc_inc;
                    end
                end
                OP_SWAP: begin
                    if (off + 1 > n) begin
                        err = ERR_UNDER;
                    end else if (off == 0) begin
                        err = ERR_SELF;
                    end else begin
                        upper                = stack_words[n-1];
                        stack_words[n-1]     = stack_words[n-1-off];
                        stack_words[n-1-off] = upper;
                        cur_pc               = pc_inc;
                    end
                end
                OP_DROP: begin
                    if (off > n) begin
                        err = ERR_UNDER;
                    end else begin
                        stack_count = 9'(n - off);
                        cur_pc      = pc_inc;
                    end
                end
                OP_PUSH_INT, OP_PUSH_TARGET: begin
                    if (n >= STACK_WORDS) begin
                        err = ERR_OVER;
                    end else begin
                        stack_words[n] = (req.op == OP_PUSH_INT) ? req.imm_value
                                                                 : {48'd0, req.target};
                        stack_count    = 9'(n + 1);
                        cur_pc         = pc_inc;
                    end
                end
                OP_GE, OP_ADD: begin
                    if (n < 2) begin
                        err = ERR_UNDER;
                    end else begin
                        lower = stack_words[n-2];
                        upper = stack_words[n-1];
                        if (req.op == OP_GE) begin
                            stack_words[n-2] = ($signed(lower) >= $signed(upper)) ? 64'd1
                                                                                  : 64'd0;
                        end else begin
                            stack_words[n-2] = lower + upper;
                        end
                        stack_count = 9'(n - 1);
                        cur_pc      = pc_inc;
                    end
                end
                default: begin
                    // Label and the spare codes only step the pc.
                    cur_pc = pc_inc;
                end
            endcase
        end
        rsp.next_pc   = cur_pc;
        rsp.top_value = (stack_count != 0) ? stack_words[stack_count-1] : '0;
        rsp.depth     = stack_count;
        rsp.halted    = is_halted;
        rsp.error     = err;
        fault_hits[err]++;
        return rsp;
    endfunction

    function automatic sme_req_t mk(input logic [3:0] op, input logic [63:0] imm,
                                    input logic [8:0] off, input logic [15:0] tgt);
        sme_req_t req;
        req.op           = op;
        req.imm_value    = imm;
        req.stack_offset = off;
        req.target       = tgt;
        return req;
    endfunction

    function automatic logic [63:0] rnd_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [8:0] rnd_off();
        return 9'($urandom_range(0, STACK_WORDS));
    endfunction

    function automatic logic [15:0] rnd_tgt();
        return 16'($urandom);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Immediates lean toward zero and the signed extremes, since those are
    // what jz, ge and add wrap-around care about.
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 64'($urandom_range(1, 7));
            2: return -64'($urandom_range(1, 7));
            3: return WORD_MAX;
            4: return WORD_MIN;
            default: return rnd_word();
        endcase
    endfunction

    // Offsets are mostly legal for the current depth and often small; one in
    // ten is any value from 0 to STACK_WORDS. span is the number of legal values.
    function automatic logic [8:0] pick_offset(input int span);
        if (span == 0 || $urandom_range(0, 9) == 0) begin
            return rnd_off();
        end
        if ($urandom_range(0, 1) != 0) begin
            return 9'($urandom_range(0, (span > 4) ? 3 : span - 1));
        end
        return 9'($urandom_range(0, span - 1));
    endfunction

    // Sends one request. The caller is always at a rising edge. With no gap,
    // valid simply stays high and only the payload changes; otherwise valid
    // drops for the gap. Prediction happens at the accepting edge.
    task automatic send_instr(input sme_req_t req);
        int       gap;
        sme_rsp_t want_rsp;
        gap = sender_eager ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want_rsp        = execute_instr(req);
        pending_results = {pending_results, want_rsp};
        instr_count++;
        if (int'(stack_count) > deepest) begin
            deepest = int'(stack_count);
        end
    endtask

    // Holds off the request side until every response is back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Faults on an empty stack, the signed extremes, add wrap-around, ge as a
    // full 0/1 word, jz on a word whose low bits are zero, pc wrap, swap with
    // itself, ret and the spare opcodes.
    task automatic test_corner_cases();
        send_instr(mk(OP_JZ, rnd_word(), rnd_off(), 16'h0001));
        send_instr(mk(OP_RET, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_ADD, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd0, rnd_tgt()));
        send_instr(mk(OP_SWAP, rnd_word(), 9'd1, rnd_tgt()));
        send_instr(mk(OP_DROP, rnd_word(), 9'd1, rnd_tgt()));
        send_instr(mk(OP_DROP, rnd_word(), 9'd0, rnd_tgt()));
        send_instr(mk(OP_LABEL, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_SPARE_HI, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_INT, WORD_MAX, rnd_off(), rnd_tgt()));
        send_instr(mk(OP_GE, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_INT, WORD_MIN, rnd_off(), rnd_tgt()));
        send_instr(mk(OP_GE, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_INT, WORD_ONES, rnd_off(), rnd_tgt()));
        send_instr(mk(OP_ADD, rnd_word(), rnd_off(), rnd_tgt()));
        // Top is zero now, so this jumps to the last address; the spare opcode
        // after it wraps the pc back to zero.
        send_instr(mk(OP_JZ, rnd_word(), rnd_off(), 16'hffff));
        send_instr(mk(OP_SPARE_LO, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_TARGET, rnd_word(), rnd_off(), 16'hffff));
        send_instr(mk(OP_PUSH_INT, '0, rnd_off(), rnd_tgt()));
        send_instr(mk(OP_SWAP, rnd_word(), 9'd0, rnd_tgt()));
        send_instr(mk(OP_SWAP, rnd_word(), 9'd1, rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd1, rnd_tgt()));
        send_instr(mk(OP_RET, rnd_word(), rnd_off(), rnd_tgt()));
        // Only the sign bit is set, so jz must fall through.
        send_instr(mk(OP_PUSH_INT, WORD_MIN, rnd_off(), rnd_tgt()));
        send_instr(mk(OP_JZ, rnd_word(), rnd_off(), 16'h1234));
        send_instr(mk(OP_JUMP, rnd_word(), rnd_off(), 16'h0000));
    endtask

    // Fills the stack to the last entry and probes overflow, the deepest
    // legal offset and the largest count.
    task automatic test_stack_limits();
        send_instr(mk(OP_DROP, rnd_word(), stack_count, rnd_tgt()));
        while (stack_count < STACK_WORDS) begin
            if ($urandom_range(0, 3) == 0) begin
                send_instr(mk(OP_PUSH_TARGET, rnd_word(), rnd_off(), rnd_tgt()));
            end else begin
                send_instr(mk(OP_PUSH_INT, pick_word(), rnd_off(), rnd_tgt()));
            end
        end
        send_instr(mk(OP_PUSH_INT, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_TARGET, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd0, rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd255, rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd256, rnd_tgt()));
        send_instr(mk(OP_SWAP, rnd_word(), 9'd255, rnd_tgt()));
        send_instr(mk(OP_SWAP, rnd_word(), 9'd256, rnd_tgt()));
        send_instr(mk(OP_ADD, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_DROP, rnd_word(), stack_count, rnd_tgt()));
        send_instr(mk(OP_DROP, rnd_word(), 9'd256, rnd_tgt()));
        send_instr(mk(OP_RET, rnd_word(), rnd_off(), rnd_tgt()));
    endtask

    // Random programs. The run moves between phases that grow the stack and
    // phases that shrink it, so the depth sweeps its range, and between
    // stretches of back-to-back requests and stretches with gaps.
    task automatic test_random_program(input int count);
        bit          filling;
        int          roll;
        logic [3:0]  op;
        logic [8:0]  off;
        filling = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) begin
                filling      = ($urandom_range(0, 9) < 6);
                sender_eager = ($urandom_range(0, 3) == 0);
            end
            // Let the block run dry now and then.
            if (i % 250 == 249) begin
                wait_idle();
            end
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 60 : 15)) begin
                op = ($urandom_range(0, 3) == 0) ? OP_PUSH_TARGET : OP_PUSH_INT;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1, 14: op = OP_DUP;
                    2, 3:     op = OP_SWAP;
                    4:        op = OP_DROP;
                    5, 6:     op = OP_GE;
                    7, 8, 15: op = OP_ADD;
                    9:        op = OP_JZ;
                    10:       op = OP_RET;
                    11:       op = OP_JUMP;
                    12:       op = OP_LABEL;
                    default:  op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                endcase
            end
            if (op == OP_DROP) begin
                off = filling ? pick_offset((stack_count < 3) ? int'(stack_count) + 1 : 3)
                              : pick_offset(int'(stack_count) + 1);
            end else if (op == OP_DUP || op == OP_SWAP) begin
                off = pick_offset(int'(stack_count));
            end else begin
                off = rnd_off();
            end
            send_instr(mk(op, pick_word(), off, rnd_tgt()));
        end
        sender_eager = 1'b0;
    endtask

    // Halt is final: once it executes nothing else can change the state, so
    // this runs last.
    task automatic test_halt();
        send_instr(mk(OP_PUSH_INT, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_HALT, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_JUMP, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_PUSH_INT, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_DUP, rnd_word(), 9'd0, rnd_tgt()));
        send_instr(mk(OP_DROP, rnd_word(), 9'd1, rnd_tgt()));
        send_instr(mk(OP_ADD, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_HALT, rnd_word(), rnd_off(), rnd_tgt()));
        send_instr(mk(OP_SPARE_HI, rnd_word(), rnd_off(), rnd_tgt()));
    endtask

    // Response side back-pressure: long stretches of ready, short runs
    // broken by gaps of random length.
    initial begin : rsp_stall_gen
        int run_len;
        int stall_len;
        @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150)
                                                  : $urandom_range(1, 6);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // Every response taken at an edge is checked against the oldest one owed.
    always @(posedge aclk) begin : rsp_check
        sme_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding: %h", m_rsp);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_rsp.next_pc !== want.next_pc) begin
                    $error("next_pc mismatch: expected %h, got %h",
                           want.next_pc, m_rsp.next_pc);
                    fail_count++;
                end
                if (m_rsp.top_value !== want.top_value) begin
                    $error("top_value mismatch: expected %h, got %h",
                           want.top_value, m_rsp.top_value);
                    fail_count++;
                end
                if (m_rsp.depth !== want.depth) begin
                    $error("depth mismatch: expected %0d, got %0d",
                           want.depth, m_rsp.depth);
                    fail_count++;
                end
                if (m_rsp.halted !== want.halted) begin
                    $error("halted mismatch: expected %b, got %b",
                           want.halted, m_rsp.halted);
                    fail_count++;
                end
                if (m_rsp.error !== want.error) begin
                    $error("error mismatch: expected %0d, got %0d",
                           want.error, m_rsp.error);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then the drain.
    initial begin : main_seq
        int guard;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_cases();
        test_stack_limits();
        test_random_program(480);
        test_stack_limits();
        test_halt();
        s_valid <= 1'b0;
        guard = 0;
        @(posedge aclk);
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d responses never arrived", pending_results.size());
            fail_count++;
        end
        // A few more edges to catch any stray response.
        repeat (20) @(posedge aclk);
        $display("Executed %0d instructions, checked %0d responses, stack reached %0d words.",
                 instr_count, result_count, deepest);
        $display("Faults: %0d underflow, %0d overflow, %0d self swap, %0d after halt.",
                 fault_hits[ERR_UNDER], fault_hits[ERR_OVER], fault_hits[ERR_SELF],
                 fault_hits[ERR_HALTED]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin : watchdog
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: stack_machine_execute.f
rtl/sme_pkg.sv
rtl/sme_stack_ram.sv
rtl/stack_machine_execute.sv
bench/stack_machine_execute_tb.sv
